// File: design/sdh_pkg.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer package
// Shared types, codes and helpers for the sequencer and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package sdh_pkg;

   // Block geometry and write buffer memory shape.
   localparam int BLOCK_BYTES = 512;
   localparam int BUF_AW      = $clog2(BLOCK_BYTES);
   localparam int BUF_DW      = 8;
   localparam int BC_W        = 10;
   localparam int CSR_IDX_W   = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_LIMIT  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_LIMIT = 1'd1;

   // Operation codes.
   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_LOAD  = 3'd3;
   localparam logic [2:0] OP_RX    = 3'd4;

   // Completion status codes.
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_NOT_INIT     = 4'd1;
   localparam logic [3:0] ST_RESET_TMO    = 4'd2;
   localparam logic [3:0] ST_INIT_TMO     = 4'd3;
   localparam logic [3:0] ST_OCR_ERR      = 4'd4;
   localparam logic [3:0] ST_CMD_REJECT   = 4'd5;
   localparam logic [3:0] ST_TOKEN_TMO    = 4'd6;
   localparam logic [3:0] ST_WRITE_REJECT = 4'd7;
   localparam logic [3:0] ST_BUSY_TMO     = 4'd8;
   localparam logic [3:0] ST_BUSY         = 4'd9;

   // Protocol bytes and arguments.
   localparam logic [7:0]  IDLE_BYTE   = 8'hff;
   localparam logic [7:0]  DATA_TOKEN  = 8'hfe;
   localparam logic [7:0]  CMD_START   = 8'h40;
   localparam logic [7:0]  CRC_CMD0    = 8'h95;
   localparam logic [7:0]  CRC_CMD8    = 8'h87;
   localparam logic [7:0]  R1_IDLE     = 8'h01;
   localparam logic [4:0]  DRESP_OK    = 5'h05;
   localparam logic [31:0] ARG_CMD8    = 32'h0000_01aa;
   localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;

   // Sequencer phases.
   typedef enum logic [4:0] {
      PH_IDLE, PH_WAKE, PH_C0, PH_C8, PH_C55, PH_C41, PH_C58, PH_C17, PH_C24,
      PH_C8_EXTRA, PH_C58_TAIL, PH_TOKEN, PH_RDATA, PH_WDATA, PH_BUSY,
      PH_T0, PH_T8, PH_T55, PH_T41, PH_TEND
   } phase_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] block_number;
      logic [7:0]  write_data;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       chip_select;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic [3:0] status;
   } rsp_type;

   // Result of one step; the transmit byte may come from the buffer read port.
   typedef struct packed {
      rsp_type rsp;
      logic    from_buf;
   } step_type;

   // Write buffer access for one step.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [BUF_AW-1:0] addr;
      logic [BUF_DW-1:0] wdata;
   } buf_ctl_type;

   // Command index byte for a command phase.
   function automatic logic [7:0] cmd_index(input phase_type ph);
      logic [7:0] idx;
      case (ph)
         PH_C0:   idx = 8'd0;
         PH_C8:   idx = 8'd8;
         PH_C55:  idx = 8'd55;
         PH_C41:  idx = 8'd41;
         PH_C58:  idx = 8'd58;
         PH_C17:  idx = 8'd17;
         PH_C24:  idx = 8'd24;
         default: idx = 8'd0;
      endcase
      return CMD_START | idx;
   endfunction

endpackage

`default_nettype wire

// File: design/sdh_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/sdh_seq.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer control
// Holds the protocol state and works out one result for each accepted item.
// ----------------------------------------------------------------------------
`default_nettype none

module sdh_seq
   import sdh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire req_type              req,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   output step_type                  result,
   output buf_ctl_type               buf_ctl
);

   phase_type   phase_ff, phase_in;
   logic [BC_W-1:0] bc_ff, bc_in;
   logic [15:0] poll_ff, poll_in;
   logic [15:0] retry_ff, retry_in;
   logic [31:0] arg_ff, arg_in;
   logic [BUF_AW-1:0] lp_ff, lp_in;
   logic        ready_ff, ready_in;
   logic        ba_ff, ba_in;
   logic [15:0] poll_limit_ff, retry_limit_ff;

   // Shared conditions.
   logic [15:0] plim, rlim;
   logic        running, busy_refuse, rx_step, in_cmd, poll_more, retry_done;
   logic        cmd_resp, resp_bad, acmd_bad, r_idle;
   logic [7:0]  rx, resp_r, r_ff;
   logic [31:0] addr_arg, tail_arg;

   assign plim        = (poll_limit_ff == 16'd0) ? 16'd1 : poll_limit_ff;
   assign rlim        = (retry_limit_ff == 16'd0) ? 16'd1 : retry_limit_ff;
   assign running     = (phase_ff != PH_IDLE);
   assign busy_refuse = running && (req.operation <= OP_LOAD);
   assign rx_step     = running && (req.operation == OP_RX);
   assign rx          = req.rx_byte;
   assign r_ff        = arg_ff[7:0];
   assign in_cmd      = (phase_ff >= PH_C0) && (phase_ff <= PH_C24);
   assign poll_more   = (poll_ff < plim);
   assign retry_done  = ((17'(retry_ff) + 17'd1) >= 17'(rlim));
   assign cmd_resp    = in_cmd && (bc_ff >= BC_W'(7)) && (!rx[7] || !poll_more);
   assign resp_r      = rx[7] ? IDLE_BYTE : rx;
   assign resp_bad    = (resp_r != 8'd0);
   assign r_idle      = (r_ff == R1_IDLE);
   assign acmd_bad    = (phase_ff == PH_T55) ? (r_ff > R1_IDLE) : (r_ff != 8'd0);
   assign addr_arg    = ba_ff ? req.block_number : {req.block_number[22:0], 9'd0};
   assign tail_arg    = (bc_ff == '0) ? (arg_ff | {16'd0, rx, 8'd0}) : arg_ff;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (busy_refuse) begin
         phase_in = phase_ff;
      end else if (req.operation == OP_INIT) begin
         phase_in = PH_WAKE;
      end else if (req.operation == OP_READ || req.operation == OP_WRITE) begin
         if (!ready_ff) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = (req.operation == OP_READ) ? PH_C17 : PH_C24;
         end
      end else if (rx_step) begin
         case (phase_ff)
            PH_C0, PH_C8, PH_C55, PH_C41, PH_C58, PH_C17, PH_C24: begin
               if (cmd_resp) begin
                  case (phase_ff)
                     PH_C0:   phase_in = PH_T0;
                     PH_C8:   phase_in = (resp_r == R1_IDLE) ? PH_C8_EXTRA : PH_T8;
                     PH_C55:  phase_in = PH_T55;
                     PH_C41:  phase_in = PH_T41;
                     PH_C58:  phase_in = PH_C58_TAIL;
                     PH_C17:  phase_in = resp_bad ? PH_TEND : PH_TOKEN;
                     default: phase_in = resp_bad ? PH_TEND : PH_WDATA;
                  endcase
               end
            end
            PH_WAKE: begin
               if (bc_ff >= BC_W'(9)) begin
                  phase_in = PH_C0;
               end
            end
            PH_C8_EXTRA: begin
               if (bc_ff >= BC_W'(3)) begin
                  phase_in = PH_T8;
               end
            end
            PH_T0: begin
               if (r_idle) begin
                  phase_in = PH_C8;
               end else begin
                  phase_in = retry_done ? PH_IDLE : PH_C0;
               end
            end
            PH_T8: phase_in = PH_C55;
            PH_T55, PH_T41: begin
               if (acmd_bad) begin
                  phase_in = retry_done ? PH_IDLE : PH_C55;
               end else begin
                  phase_in = (phase_ff == PH_T55) ? PH_C41 : PH_C58;
               end
            end
            PH_C58_TAIL: begin
               if (bc_ff >= BC_W'(3)) begin
                  phase_in = PH_TEND;
               end
            end
            PH_TOKEN: begin
               if (rx == DATA_TOKEN) begin
                  phase_in = PH_RDATA;
               end else if (!poll_more) begin
                  phase_in = PH_TEND;
               end
            end
            PH_RDATA: begin
               if (bc_ff >= BC_W'(BLOCK_BYTES + 1)) begin
                  phase_in = PH_TEND;
               end
            end
            PH_WDATA: begin
               if (bc_ff >= BC_W'(BLOCK_BYTES + 3)) begin
                  phase_in = (rx[4:0] == DRESP_OK) ? PH_BUSY : PH_TEND;
               end
            end
            PH_BUSY: begin
               if (rx == IDLE_BYTE || !poll_more) begin
                  phase_in = PH_TEND;
               end
            end
            PH_TEND: phase_in = PH_IDLE;
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Counters, argument register, buffer access and the step result.
   always_comb begin
      bc_in    = bc_ff;
      poll_in  = poll_ff;
      retry_in = retry_ff;
      arg_in   = arg_ff;
      lp_in    = lp_ff;
      ready_in = ready_ff;
      ba_in    = ba_ff;
      result   = '0;
      buf_ctl.wr_en = 1'b0;
      buf_ctl.rd_en = step;
      buf_ctl.addr  = bc_ff[BUF_AW-1:0];
      buf_ctl.wdata = req.write_data;

      if (busy_refuse) begin
         result.rsp.status = ST_BUSY;
      end else if (req.operation == OP_INIT) begin
         ready_in = 1'b0;
         ba_in    = 1'b0;
         bc_in    = '0;
         retry_in = '0;
         result.rsp.tx_valid = 1'b1;
         result.rsp.tx_byte  = IDLE_BYTE;
      end else if (req.operation == OP_READ || req.operation == OP_WRITE) begin
         if (req.operation == OP_WRITE) begin
            lp_in = '0;
         end
         if (!ready_ff) begin
            result.rsp.done_res = 1'b1;
            result.rsp.status   = ST_NOT_INIT;
         end else begin
            bc_in  = '0;
            arg_in = addr_arg;
            result.rsp.tx_valid    = 1'b1;
            result.rsp.tx_byte     = IDLE_BYTE;
            result.rsp.chip_select = 1'b1;
         end
      end else if (req.operation == OP_LOAD) begin
         buf_ctl.wr_en = step;
         buf_ctl.rd_en = 1'b0;
         buf_ctl.addr  = lp_ff;
         lp_in         = lp_ff + BUF_AW'(1);
      end else if (rx_step) begin
         // Most steps send an idle byte with the card selected.
         result.rsp.tx_valid    = 1'b1;
         result.rsp.tx_byte     = IDLE_BYTE;
         result.rsp.chip_select = 1'b1;
         case (phase_ff)
            PH_C0, PH_C8, PH_C55, PH_C41, PH_C58, PH_C17, PH_C24: begin
               if (bc_ff < BC_W'(6)) begin
                  bc_in = bc_ff + BC_W'(1);
                  case (bc_ff)
                     BC_W'(0): result.rsp.tx_byte = cmd_index(phase_ff);
                     BC_W'(1): result.rsp.tx_byte = arg_ff[31:24];
                     BC_W'(2): result.rsp.tx_byte = arg_ff[23:16];
                     BC_W'(3): result.rsp.tx_byte = arg_ff[15:8];
                     BC_W'(4): result.rsp.tx_byte = arg_ff[7:0];
                     default: begin
                        if (phase_ff == PH_C0) begin
                           result.rsp.tx_byte = CRC_CMD0;
                        end else if (phase_ff == PH_C8) begin
                           result.rsp.tx_byte = CRC_CMD8;
                        end else begin
                           result.rsp.tx_byte = IDLE_BYTE;
                        end
                     end
                  endcase
               end else if (bc_ff == BC_W'(6)) begin
                  bc_in   = BC_W'(7);
                  poll_in = 16'd1;
               end else if (!cmd_resp) begin
                  poll_in = poll_ff + 16'd1;
               end else begin
                  case (phase_ff)
                     PH_C0, PH_C55, PH_C41: begin
                        arg_in = {24'd0, resp_r};
                        result.rsp.chip_select = 1'b0;
                     end
                     PH_C8: begin
                        bc_in = '0;
                        result.rsp.chip_select = (resp_r == R1_IDLE);
                     end
                     PH_C58: begin
                        arg_in = {24'd0, resp_r};
                        bc_in  = '0;
                     end
                     PH_C17: begin
                        if (resp_bad) begin
                           arg_in = {28'd0, ST_CMD_REJECT};
                           result.rsp.chip_select = 1'b0;
                        end else begin
                           poll_in = 16'd1;
                        end
                     end
                     default: begin
                        if (resp_bad) begin
                           arg_in = {28'd0, ST_CMD_REJECT};
                           result.rsp.chip_select = 1'b0;
                        end else begin
                           bc_in = '0;
                           result.rsp.tx_byte = DATA_TOKEN;
                        end
                     end
                  endcase
               end
            end
            PH_WAKE: begin
               bc_in = bc_ff + BC_W'(1);
               if (bc_ff < BC_W'(9)) begin
                  result.rsp.chip_select = 1'b0;
               end else begin
                  retry_in = '0;
                  bc_in    = '0;
                  arg_in   = '0;
               end
            end
            PH_C8_EXTRA: begin
               bc_in = bc_ff + BC_W'(1);
               if (bc_ff >= BC_W'(3)) begin
                  result.rsp.chip_select = 1'b0;
               end
            end
            PH_T0: begin
               if (r_idle) begin
                  bc_in  = '0;
                  arg_in = ARG_CMD8;
               end else begin
                  retry_in = retry_ff + 16'd1;
                  if (retry_done) begin
                     result.rsp          = '0;
                     result.rsp.done_res = 1'b1;
                     result.rsp.status   = ST_RESET_TMO;
                  end else begin
                     bc_in  = '0;
                     arg_in = '0;
                  end
               end
            end
            PH_T8: begin
               retry_in = '0;
               bc_in    = '0;
               arg_in   = '0;
            end
            PH_T55, PH_T41: begin
               if (acmd_bad) begin
                  retry_in = retry_ff + 16'd1;
                  if (retry_done) begin
                     result.rsp          = '0;
                     result.rsp.done_res = 1'b1;
                     result.rsp.status   = ST_INIT_TMO;
                  end else begin
                     bc_in  = '0;
                     arg_in = '0;
                  end
               end else begin
                  bc_in  = '0;
                  arg_in = (phase_ff == PH_T55) ? ARG_ACMD41 : 32'd0;
               end
            end
            PH_C58_TAIL: begin
               bc_in  = bc_ff + BC_W'(1);
               arg_in = tail_arg;
               if (bc_ff >= BC_W'(3)) begin
                  result.rsp.chip_select = 1'b0;
                  if (tail_arg[7:0] != 8'd0) begin
                     arg_in = {28'd0, ST_OCR_ERR};
                  end else begin
                     ba_in    = tail_arg[14];
                     ready_in = 1'b1;
                     arg_in   = {28'd0, ST_OK};
                  end
               end
            end
            PH_TOKEN: begin
               if (rx == DATA_TOKEN) begin
                  bc_in = '0;
               end else if (poll_more) begin
                  poll_in = poll_ff + 16'd1;
               end else begin
                  arg_in = {28'd0, ST_TOKEN_TMO};
                  result.rsp.chip_select = 1'b0;
               end
            end
            PH_RDATA: begin
               if (bc_ff < BC_W'(BLOCK_BYTES)) begin
                  result.rsp.read_valid = 1'b1;
                  result.rsp.read_byte  = rx;
               end
               bc_in = bc_ff + BC_W'(1);
               if (bc_ff >= BC_W'(BLOCK_BYTES + 1)) begin
                  arg_in = {28'd0, ST_OK};
                  result.rsp.chip_select = 1'b0;
               end
            end
            PH_WDATA: begin
               if (bc_ff >= BC_W'(BLOCK_BYTES + 3)) begin
                  if (rx[4:0] == DRESP_OK) begin
                     poll_in = 16'd1;
                  end else begin
                     arg_in = {28'd0, ST_WRITE_REJECT};
                     result.rsp.chip_select = 1'b0;
                  end
               end else begin
                  bc_in = bc_ff + BC_W'(1);
                  // Data bytes come from the buffer read issued this cycle.
                  if (bc_ff < BC_W'(BLOCK_BYTES)) begin
                     result.from_buf = 1'b1;
                  end
               end
            end
            PH_BUSY: begin
               if (rx == IDLE_BYTE) begin
                  arg_in = {28'd0, ST_OK};
                  result.rsp.chip_select = 1'b0;
               end else if (poll_more) begin
                  poll_in = poll_ff + 16'd1;
               end else begin
                  arg_in = {28'd0, ST_BUSY_TMO};
                  result.rsp.chip_select = 1'b0;
               end
            end
            PH_TEND: begin
               result.rsp          = '0;
               result.rsp.done_res = 1'b1;
               result.rsp.status   = arg_ff[3:0];
            end
            default: result.rsp = '0;
         endcase
      end
   end

   // State registers, advanced once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bc_ff    <= '0;
         poll_ff  <= '0;
         retry_ff <= '0;
         arg_ff   <= '0;
         lp_ff    <= '0;
         ready_ff <= 1'b0;
         ba_ff    <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         poll_ff  <= poll_in;
         retry_ff <= retry_in;
         arg_ff   <= arg_in;
         lp_ff    <= lp_in;
         ready_ff <= ready_in;
         ba_ff    <= ba_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff  <= 16'd1000;
         retry_limit_ff <= 16'd1000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLL_LIMIT:  poll_limit_ff  <= csr_wdata;
            CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// File: design/sd_card_spi_host_sequencer_core.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// Steps SPI-mode init, single block read and single block write one byte a time.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result item, in the cycle after it
// is accepted; a new item is accepted in every cycle in which the result
// register is empty or being taken, so the block sustains one item per cycle.
// The write block buffer is a 512 x 8 single-port RAM: a load item writes it,
// and each data step of a write reads it, with the read byte landing straight
// in the result. Configuration registers may be written at any time the
// sequencer is idle; the write port is always ready.
`default_nettype none

module sd_card_spi_host_sequencer_core
   import sdh_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   logic        step;
   step_type    result;
   buf_ctl_type buf_ctl;
   logic [BUF_DW-1:0] buf_rdata;
   step_type    res_ff;
   logic        rsp_valid_ff, rsp_valid_in;

   // Accept while the result register is empty or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   sdh_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .req       (req_payload),
      .csr_we    (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result),
      .buf_ctl   (buf_ctl)
   );

   sdh_ram #(
      .WIDTH (BUF_DW),
      .DEPTH (BLOCK_BYTES)
   ) u_buf (
      .clock (clock),
      .wr_en (buf_ctl.wr_en),
      .rd_en (buf_ctl.rd_en),
      .addr  (buf_ctl.addr),
      .wdata (buf_ctl.wdata),
      .rdata (buf_rdata)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         res_ff <= result;
      end
   end

   // Buffer data replaces the transmit byte during write data steps.
   always_comb begin
      rsp_payload = res_ff.rsp;
      if (res_ff.from_buf) begin
         rsp_payload.tx_byte = buf_rdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted item always leaves a result behind it.
   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid)
      else $error("accepted item produced no result");

   // Input is held off only while a result is waiting.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result register");

   // Buffer bytes are only ever sent with the card selected.
   a_buf_selected: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && res_ff.from_buf) |-> (rsp_payload.tx_valid && rsp_payload.chip_select))
      else $error("buffer byte sent without chip select");

   // A finishing result requests no exchange.
   a_done_no_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.done_res) |-> !rsp_payload.tx_valid)
      else $error("done result also requests an exchange");

endmodule

`default_nettype wire

// File: test/sd_card_spi_host_sequencer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD card SPI host sequencer checker
// Watches the request, response and register channels, keeps its own copy of
// the sequencer state, works out the result of every accepted item and
// compares each accepted result field by field with the oldest expectation.
// ----------------------------------------------------------------------------

module sd_card_spi_host_sequencer_checker
   import sdh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_wdata,
   output int                   fail_count,
   output int                   pending_count,
   output int                   result_count,
   output logic                 seq_idle
);

   // Mirror of the configuration and of the sequencer state.
   logic [15:0] poll_lim, retry_lim;
   phase_type   ph;
   logic [9:0]  byte_cnt;
   logic [15:0] poll_cnt, retry_cnt;
   logic        card_ok, blk_addr;
   logic [31:0] cmd_arg;
   logic [8:0]  load_ptr;
   logic [7:0]  wbuf [BLOCK_BYTES];
   rsp_type     outcome;
   rsp_type     expected_results [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_count  = 0;
      seq_idle      = 1'b1;
   end

   function automatic logic [15:0] at_least_one(input logic [15:0] v);
      return (v == 16'd0) ? 16'd1 : v;
   endfunction

   task automatic clear_state();
      poll_lim  = 16'd1000;
      retry_lim = 16'd1000;
      ph        = PH_IDLE;
      byte_cnt  = '0;
      poll_cnt  = '0;
      retry_cnt = '0;
      card_ok   = 1'b0;
      blk_addr  = 1'b0;
      cmd_arg   = '0;
      load_ptr  = '0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic sel);
      outcome.tx_valid    = 1'b1;
      outcome.tx_byte     = b;
      outcome.chip_select = sel;
   endtask

   task automatic complete(input logic [3:0] st);
      ph               = PH_IDLE;
      outcome.done_res = 1'b1;
      outcome.status   = st;
   endtask

   // The trailer byte carries the status until the next received byte.
   task automatic trail_with(input logic [3:0] st);
      cmd_arg = {28'd0, st};
      ph      = PH_TEND;
      send_byte(IDLE_BYTE, 1'b0);
   endtask

   task automatic open_command(input phase_type p, input logic [31:0] a);
      ph       = p;
      byte_cnt = '0;
      cmd_arg  = a;
      send_byte(IDLE_BYTE, 1'b1);
   endtask

   function automatic logic [7:0] command_byte(input logic [9:0] k);
      logic [7:0] idx;
      case (ph)
         PH_C8:   idx = 8'd8;
         PH_C55:  idx = 8'd55;
         PH_C41:  idx = 8'd41;
         PH_C58:  idx = 8'd58;
         PH_C17:  idx = 8'd17;
         PH_C24:  idx = 8'd24;
         default: idx = 8'd0;
      endcase
      if (k == 10'd1) return CMD_START | idx;
      if (k >= 10'd2 && k <= 10'd5) return 8'((cmd_arg >> (8 * (5 - k))) & 32'hff);
      if (ph == PH_C0) return CRC_CMD0;
      if (ph == PH_C8) return CRC_CMD8;
      return IDLE_BYTE;
   endfunction

   task automatic acmd_retry();
      retry_cnt++;
      if (retry_cnt >= at_least_one(retry_lim)) complete(ST_INIT_TMO);
      else open_command(PH_C55, '0);
   endtask

   // What follows the R1 response of each command.
   task automatic take_response(input logic [7:0] r);
      case (ph)
         PH_C0, PH_C55, PH_C41: begin
            cmd_arg = {24'd0, r};
            ph = (ph == PH_C0) ? PH_T0 : (ph == PH_C55) ? PH_T55 : PH_T41;
            send_byte(IDLE_BYTE, 1'b0);
         end
         PH_C8: begin
            byte_cnt = '0;
            if (r == R1_IDLE) begin
               ph = PH_C8_EXTRA;
               send_byte(IDLE_BYTE, 1'b1);
            end else begin
               ph = PH_T8;
               send_byte(IDLE_BYTE, 1'b0);
            end
         end
         PH_C58: begin
            cmd_arg  = {24'd0, r};
            ph       = PH_C58_TAIL;
            byte_cnt = '0;
            send_byte(IDLE_BYTE, 1'b1);
         end
         PH_C17: begin
            if (r != 8'd0) trail_with(ST_CMD_REJECT);
            else begin
               ph       = PH_TOKEN;
               poll_cnt = 16'd1;
               send_byte(IDLE_BYTE, 1'b1);
            end
         end
         default: begin
            if (r != 8'd0) trail_with(ST_CMD_REJECT);
            else begin
               ph       = PH_WDATA;
               byte_cnt = '0;
               send_byte(DATA_TOKEN, 1'b1);
            end
         end
      endcase
   endtask

   // One received byte while an operation runs.
   task automatic take_rx(input logic [7:0] rx);
      logic [7:0] r;
      r = cmd_arg[7:0];
      if (ph >= PH_C0 && ph <= PH_C24) begin
         if (byte_cnt < 10'd6) begin
            byte_cnt++;
            send_byte(command_byte(byte_cnt), 1'b1);
         end else if (byte_cnt == 10'd6) begin
            byte_cnt = 10'd7;
            poll_cnt = 16'd1;
            send_byte(IDLE_BYTE, 1'b1);
         end else if (!rx[7]) begin
            take_response(rx);
         end else if (poll_cnt < at_least_one(poll_lim)) begin
            poll_cnt++;
            send_byte(IDLE_BYTE, 1'b1);
         end else begin
            take_response(IDLE_BYTE);
         end
         return;
      end
      case (ph)
         PH_WAKE: begin
            byte_cnt++;
            if (byte_cnt < 10'd10) send_byte(IDLE_BYTE, 1'b0);
            else begin
               retry_cnt = '0;
               open_command(PH_C0, '0);
            end
         end
         PH_C8_EXTRA: begin
            byte_cnt++;
            if (byte_cnt < 10'd4) send_byte(IDLE_BYTE, 1'b1);
            else begin
               ph = PH_T8;
               send_byte(IDLE_BYTE, 1'b0);
            end
         end
         PH_T0: begin
            if (r == R1_IDLE) open_command(PH_C8, ARG_CMD8);
            else begin
               retry_cnt++;
               if (retry_cnt >= at_least_one(retry_lim)) complete(ST_RESET_TMO);
               else open_command(PH_C0, '0);
            end
         end
         PH_T8: begin
            retry_cnt = '0;
            open_command(PH_C55, '0);
         end
         PH_T55: begin
            if (r > R1_IDLE) acmd_retry();
            else open_command(PH_C41, ARG_ACMD41);
         end
         PH_T41: begin
            if (r == 8'd0) open_command(PH_C58, '0);
            else acmd_retry();
         end
         PH_C58_TAIL: begin
            if (byte_cnt == 10'd0) cmd_arg[15:8] = cmd_arg[15:8] | rx;
            byte_cnt++;
            if (byte_cnt < 10'd4) send_byte(IDLE_BYTE, 1'b1);
            else if (r != 8'd0) trail_with(ST_OCR_ERR);
            else begin
               blk_addr = cmd_arg[14];
               card_ok  = 1'b1;
               trail_with(ST_OK);
            end
         end
         PH_TOKEN: begin
            if (rx == DATA_TOKEN) begin
               ph       = PH_RDATA;
               byte_cnt = '0;
               send_byte(IDLE_BYTE, 1'b1);
            end else if (poll_cnt < at_least_one(poll_lim)) begin
               poll_cnt++;
               send_byte(IDLE_BYTE, 1'b1);
            end else begin
               trail_with(ST_TOKEN_TMO);
            end
         end
         PH_RDATA: begin
            if (byte_cnt < BLOCK_BYTES) begin
               outcome.read_valid = 1'b1;
               outcome.read_byte  = rx;
            end
            byte_cnt++;
            if (byte_cnt < BLOCK_BYTES + 2) send_byte(IDLE_BYTE, 1'b1);
            else trail_with(ST_OK);
         end
         PH_WDATA: begin
            if (byte_cnt >= BLOCK_BYTES + 3) begin
               if (rx[4:0] == DRESP_OK) begin
                  ph       = PH_BUSY;
                  poll_cnt = 16'd1;
                  send_byte(IDLE_BYTE, 1'b1);
               end else begin
                  trail_with(ST_WRITE_REJECT);
               end
            end else begin
               byte_cnt++;
               if (byte_cnt <= BLOCK_BYTES) send_byte(wbuf[9'(byte_cnt - 1)], 1'b1);
               else send_byte(IDLE_BYTE, 1'b1);
            end
         end
         PH_BUSY: begin
            if (rx == IDLE_BYTE) trail_with(ST_OK);
            else if (poll_cnt < at_least_one(poll_lim)) begin
               poll_cnt++;
               send_byte(IDLE_BYTE, 1'b1);
            end else begin
               trail_with(ST_BUSY_TMO);
            end
         end
         PH_TEND: complete(cmd_arg[3:0]);
         default: ;
      endcase
   endtask

   // Works out the result item that one accepted request item causes.
   task automatic work_out(input req_type q, output rsp_type r);
      logic running;
      running = (ph != PH_IDLE);
      outcome = '0;
      if (q.operation <= OP_LOAD && running) begin
         outcome.status = ST_BUSY;
      end else if (q.operation == OP_INIT) begin
         card_ok   = 1'b0;
         blk_addr  = 1'b0;
         ph        = PH_WAKE;
         byte_cnt  = '0;
         retry_cnt = '0;
         send_byte(IDLE_BYTE, 1'b0);
      end else if (q.operation == OP_READ || q.operation == OP_WRITE) begin
         if (q.operation == OP_WRITE) load_ptr = '0;
         if (!card_ok) complete(ST_NOT_INIT);
         else open_command((q.operation == OP_READ) ? PH_C17 : PH_C24,
                           blk_addr ? q.block_number : {q.block_number[22:0], 9'd0});
      end else if (q.operation == OP_LOAD) begin
         wbuf[load_ptr] = q.write_data;
         load_ptr++;
      end else if (q.operation == OP_RX && running) begin
         take_rx(q.rx_byte);
      end
      r = outcome;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial clear_state();

   // Results are taken before new items, since a result always follows its item.
   always @(posedge clock) begin
      rsp_type e;
      req_type q;
      if (reset) begin
         clear_state();
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_POLL_LIMIT:  poll_lim  = csr_wdata;
               CSR_RETRY_LIMIT: retry_lim = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result item", rsp_payload, 0);
            end else begin
               e = expected_results.pop_front();
               if (rsp_payload.tx_valid !== e.tx_valid)
                  report_mismatch("tx_valid", rsp_payload.tx_valid, e.tx_valid);
               if (rsp_payload.tx_byte !== e.tx_byte)
                  report_mismatch("tx_byte", rsp_payload.tx_byte, e.tx_byte);
               if (rsp_payload.chip_select !== e.chip_select)
                  report_mismatch("chip_select", rsp_payload.chip_select, e.chip_select);
               if (rsp_payload.read_valid !== e.read_valid)
                  report_mismatch("read_valid", rsp_payload.read_valid, e.read_valid);
               if (rsp_payload.read_byte !== e.read_byte)
                  report_mismatch("read_byte", rsp_payload.read_byte, e.read_byte);
               if (rsp_payload.done_res !== e.done_res)
                  report_mismatch("done_res", rsp_payload.done_res, e.done_res);
               if (rsp_payload.status !== e.status)
                  report_mismatch("status", rsp_payload.status, e.status);
            end
         end
         if (req_valid && !req_stall) begin
            q = req_payload;
            work_out(q, e);
            expected_results.push_back(e);
         end
      end
      pending_count = expected_results.size();
      seq_idle      = (ph == PH_IDLE);
   end

endmodule

// File: test/sd_card_spi_host_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD card SPI host sequencer testbench
// Plays the part of the host and of the card: sends init, read and write
// sequences with random card answers, timeouts, rejects and noise, under
// several limit settings and idling patterns. Checking is done by the checker.
// ----------------------------------------------------------------------------

module sd_card_spi_host_sequencer_core_tb;
   import sdh_pkg::*;

   localparam int QUIET_LIMIT  = 20000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TARGET_ITEMS = 1400;
   localparam int NUM_SETTINGS = 8;
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   // Idling patterns.
   typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idling_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   int         fail_count, pending_count, result_count;
   logic       seq_idle;
   idling_type idling = IDLE_NONE;
   logic       hold_req = 1'b0;
   int         items_sent = 0;
   int         inits_run = 0, reads_run = 0, writes_run = 0;
   logic [15:0] cur_poll = 16'd1000, cur_retry = 16'd1000;

   logic [15:0] poll_settings  [NUM_SETTINGS] = '{16'd1000, 16'd1, 16'd0, 16'd5,
                                                  16'd65535, 16'd3, 16'd40, 16'd2};
   logic [15:0] retry_settings [NUM_SETTINGS] = '{16'd1000, 16'd1, 16'd0, 16'd3,
                                                  16'd65535, 16'd2, 16'd4, 16'd65535};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sd_card_spi_host_sequencer_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   sd_card_spi_host_sequencer_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .result_count, .seq_idle
   );

   // Receiver side: random stalls, plus one long hold-off counted here.
   int hold_left = 0;
   bit hold_taken = 1'b0;
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idling == IDLE_RECEIVER) begin
         rsp_stall <= ($urandom_range(0, 99) < 71);
      end else if (idling == IDLE_BOTH) begin
         rsp_stall <= ($urandom_range(0, 99) < 38);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog on cycles in which no handshake of any channel completes.
   int quiet = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("sd_card_spi_host_sequencer_core_tb NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic bit sender_waits();
      if (idling == IDLE_SENDER) return $urandom_range(0, 99) < 71;
      if (idling == IDLE_BOTH) return $urandom_range(0, 99) < 38;
      return 1'b0;
   endfunction

   function automatic logic [15:0] poll_span();
      return (cur_poll == 16'd0) ? 16'd1 : cur_poll;
   endfunction

   // Offers one item from a rising edge and returns at the edge that takes it.
   task automatic send(input logic [2:0] op, input logic [31:0] blk,
                       input logic [7:0] wd, input logic [7:0] rxb);
      req_type it;
      it.operation    = op;
      it.block_number = blk;
      it.write_data   = wd;
      it.rx_byte      = rxb;
      while (sender_waits()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic rx(input logic [7:0] b);
      send(OP_RX, $urandom, 8'($urandom), b);
   endtask

   function automatic logic [7:0] not_byte(input logic [7:0] avoid);
      logic [7:0] b;
      b = 8'($urandom);
      if (b == avoid) b = ~avoid;
      return b;
   endfunction

   // Card answers the sequencer until it has gone back to idle.
   task automatic drain();
      req_valid <= 1'b0;
      forever begin
         @(negedge clock);
         if (seq_idle) break;
         @(posedge clock);
         rx(IDLE_BYTE);
         req_valid <= 1'b0;
      end
      @(posedge clock);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One command: six command bytes and a poll byte, then polls and the R1
   // byte. An R1 with bit 7 set means no answer until the poll limit.
   task automatic command(input logic [7:0] resp);
      int n;
      repeat (7) rx(8'($urandom));
      if (resp[7]) begin
         repeat (poll_span()) rx({1'b1, 7'($urandom)});
      end else begin
         n = $urandom_range(0, (poll_span() > 4) ? 3 : poll_span() - 1);
         repeat (n) rx({1'b1, 7'($urandom)});
         rx(resp);
      end
   endtask

   task automatic run_init();
      int k;
      inits_run++;
      send(OP_INIT, $urandom, 8'($urandom), 8'($urandom));
      repeat (10) rx(8'($urandom));
      // A start or load while busy is refused.
      if ($urandom_range(0, 9) == 0) send(3'($urandom_range(0, 3)), $urandom, 8'($urandom), 8'hff);
      repeat ($urandom_range(0, 2)) begin
         k = $urandom_range(0, 2);
         if (k == 0 && poll_span() <= 64) command(IDLE_BYTE);
         else command((k == 1) ? 8'h00 : 8'h05);
         rx(8'($urandom));
      end
      command(R1_IDLE);
      rx(8'($urandom));
      if ($urandom_range(0, 3) == 0) begin
         command(8'h05);
      end else begin
         command(R1_IDLE);
         repeat (4) rx(8'($urandom));
      end
      rx(8'($urandom));
      repeat ($urandom_range(0, 2)) begin
         if ($urandom_range(0, 9) == 0) begin
            command(8'h05);
            rx(8'($urandom));
         end else begin
            command(8'($urandom_range(0, 1)));
            rx(8'($urandom));
            command(R1_IDLE);
            rx(8'($urandom));
         end
      end
      command(8'($urandom_range(0, 1)));
      rx(8'($urandom));
      command(8'h00);
      rx(8'($urandom));
      command(($urandom_range(0, 9) == 0) ? R1_IDLE : 8'h00);
      repeat (4) rx(8'($urandom));
      rx(8'($urandom));
   endtask

   task automatic run_read();
      reads_run++;
      send(OP_READ, $urandom, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
         command(8'h04);
         rx(8'($urandom));
         return;
      end
      command(8'h00);
      if (poll_span() <= 64 && $urandom_range(0, 6) == 0) begin
         repeat (poll_span()) rx(not_byte(DATA_TOKEN));
      end else begin
         repeat ($urandom_range(0, (poll_span() > 4) ? 3 : poll_span() - 1))
            rx(not_byte(DATA_TOKEN));
         rx(DATA_TOKEN);
         repeat (BLOCK_BYTES + 2) rx(8'($urandom));
      end
      rx(8'($urandom));
   endtask

   task automatic run_write();
      writes_run++;
      send(OP_WRITE, $urandom, 8'($urandom), 8'($urandom));
      if ($urandom_range(0, 9) == 0) begin
         command(8'h7f);
         rx(8'($urandom));
         return;
      end
      command(8'h00);
      repeat (BLOCK_BYTES + 3) rx(8'($urandom));
      if ($urandom_range(0, 6) == 0) begin
         rx({3'($urandom), 5'h0b});
      end else begin
         rx({3'($urandom), DRESP_OK});
         if (poll_span() <= 64 && $urandom_range(0, 6) == 0) begin
            repeat (poll_span()) rx(not_byte(IDLE_BYTE));
         end else begin
            repeat ($urandom_range(0, (poll_span() > 4) ? 3 : poll_span() - 1))
               rx(not_byte(IDLE_BYTE));
            rx(IDLE_BYTE);
         end
      end
      rx(8'($urandom));
   endtask

   // Loads, stray bytes and spare operations while idle; no starts, so that
   // the card answers of the drain never have to run out long limits.
   task automatic run_noise();
      repeat ($urandom_range(1, 6)) begin
         if ($urandom_range(0, 1)) send(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                                        $urandom, 8'($urandom), 8'($urandom));
         else send(3'($urandom_range(OP_LOAD, OP_SPARE_HI)),
                   $urandom, 8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole write buffer once so that no write sends unloaded bytes.
      repeat (BLOCK_BYTES) send(OP_LOAD, $urandom, 8'($urandom), 8'($urandom));

      // Directed: starts before init, spare operations, stray bytes and loads while idle.
      send(OP_READ, 32'hffff_ffff, 8'hff, 8'hff);
      send(OP_WRITE, 32'h0, 8'h00, 8'h00);
      send(OP_SPARE_LO, 32'h0, 8'h00, 8'h00);
      send(OP_SPARE_HI, 32'hffff_ffff, 8'hff, 8'hff);
      send(OP_RX, 32'hffff_ffff, 8'hff, 8'hff);
      send(OP_RX, 32'h0, 8'h00, 8'h00);
      send(OP_LOAD, 32'h0, 8'hff, 8'h00);
      send(OP_LOAD, 32'hffff_ffff, 8'h00, 8'hff);
      wait_results();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         idling = idling_type'(s % 4);
         if (s > 0) begin
            drain();
            wait_results();
            repeat (3) @(posedge clock);
            cur_poll  = poll_settings[s];
            cur_retry = retry_settings[s];
            write_reg(CSR_POLL_LIMIT, cur_poll);
            write_reg(CSR_RETRY_LIMIT, cur_retry);
         end
         if (s == 2) hold_req <= 1'b1;
         while (items_sent < (s + 1) * TARGET_ITEMS / NUM_SETTINGS) begin
            drain();
            pick = $urandom_range(0, 99);
            if (pick < 45) run_init();
            else if (pick < 55) run_read();
            else if (pick < 65) run_write();
            else if (pick < 80) begin
               repeat ($urandom_range(1, 8)) send(OP_LOAD, $urandom, 8'($urandom), 8'($urandom));
            end else run_noise();
            if ($urandom_range(0, 9) == 0) wait_results();
         end
      end

      drain();
      wait_results();
      repeat (4) @(posedge clock);
      $display("Covered %0d items and %0d checked results: %0d inits, %0d reads, %0d writes,",
               items_sent, result_count, inits_run, reads_run, writes_run);
      $display("over %0d limit settings and four idling patterns.", NUM_SETTINGS);
      if (fail_count == 0) begin
         $display("sd_card_spi_host_sequencer_core_tb OK");
      end else begin
         $display("sd_card_spi_host_sequencer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
